FILE: rtl/core/cilp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_pkg
// Shared types and character codes for the C integer literal parser.
// ----------------------------------------------------------------------------
package cilp_pkg;

  // Scanner phase within one token
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_SUFFIX = 2'd3
  } phase_e;

  // Number base of the token
  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2,
    BASE_BIN = 2'd3
  } base_e;

  // Result type codes
  typedef enum logic [2:0] {
    TYPE_INT    = 3'd0,
    TYPE_UINT   = 3'd1,
    TYPE_LONG   = 3'd2,
    TYPE_ULONG  = 3'd3,
    TYPE_LLONG  = 3'd4,
    TYPE_ULLONG = 3'd5
  } type_code_e;

  localparam int unsigned ValueW = 64;
  localparam int unsigned NumTypes = 6;

  // Character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_B_UP  = 8'h42;
  localparam logic [7:0] CH_U_LO  = 8'h75;
  localparam logic [7:0] CH_U_UP  = 8'h55;
  localparam logic [7:0] CH_L_LO  = 8'h6c;
  localparam logic [7:0] CH_L_UP  = 8'h4c;
  localparam logic [7:0] CH_QUOTE = 8'h27;

  // Finished token handed from the scanner to the type stage
  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] value;
    logic              dec;
    logic              u;
    logic [1:0]        lc;
  } done_t;

endpackage

FILE: rtl/core/cilp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_scan
// Input register and per-character token scanner: prefix, digits with
// separators, suffix letters. Registers a finished-token record when it consumes the last beat.
// ----------------------------------------------------------------------------
module cilp_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_ch_i,
  input  logic            in_last_i,
  output logic            done_valid_o,
  input  logic            done_ready_i,
  output cilp_pkg::done_t done_o
);

  typedef struct packed {
    logic       bad;
    logic       u;
    logic [1:0] lc;
    logic       uf;
  } sfx_t;

  // Apply one suffix letter to the suffix flags
  function automatic sfx_t sfx_take(logic [7:0] c, logic u, logic [1:0] lc, logic uf);
    sfx_t r;
    r.bad = 1'b0;
    r.u   = u;
    r.lc  = lc;
    r.uf  = uf;
    if (c == cilp_pkg::CH_U_LO || c == cilp_pkg::CH_U_UP) begin
      if (u) begin
        r.bad = 1'b1;
      end else begin
        r.u = 1'b1;
        if (lc == 2'd0) r.uf = 1'b1;
      end
    end else if (c == cilp_pkg::CH_L_LO || c == cilp_pkg::CH_L_UP) begin
      if (lc >= 2'd2 || (u && !uf)) begin
        r.bad = 1'b1;
      end else begin
        r.lc = lc + 2'd1;
      end
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  // Input register
  logic       a_valid_q, a_valid_d;
  logic [7:0] a_ch_q;
  logic       a_last_q;
  logic       consume;
  logic       in_fire;

  // Token state
  cilp_pkg::phase_e           phase_q, phase_d, phase_t;
  cilp_pkg::base_e            base_q, base_d, base_t;
  logic [cilp_pkg::ValueW-1:0] accum_q, accum_d, accum_t, mac;
  logic ds_q, ds_d, ds_t;
  logic pq_q, pq_d, pq_t;
  logic su_q, su_d, su_t;
  logic [1:0] lc_q, lc_d, lc_t;
  logic uf_q, uf_d, uf_t;
  logic fail_q, fail_d, fail_t;

  // Character decode
  logic [4:0] dval;
  logic       d_ok, is_sfx, is_quote, is_x, is_b;
  sfx_t       sfx;

  // Done register
  logic            done_valid_q, done_valid_d;
  cilp_pkg::done_t done_q;
  logic            tok_ok;

  assign in_fire    = in_valid_i && in_ready_o;
  assign consume    = a_valid_q && (!a_last_q || !done_valid_q || done_ready_i);
  assign in_ready_o = !a_valid_q || consume;

  // Hold the beat until the scanner takes it
  always_comb begin
    a_valid_d = a_valid_q;
    if (consume) a_valid_d = 1'b0;
    if (in_fire) a_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_ch_q   <= in_ch_i;
      a_last_q <= in_last_i;
    end
  end

  // Decode the character
  always_comb begin
    if (a_ch_q inside {[cilp_pkg::CH_0:cilp_pkg::CH_9]}) begin
      dval = 5'(a_ch_q - cilp_pkg::CH_0);
    end else if (a_ch_q inside {[cilp_pkg::CH_A_LO:cilp_pkg::CH_F_LO]}) begin
      dval = 5'(a_ch_q - cilp_pkg::CH_A_LO + 8'd10);
    end else if (a_ch_q inside {[cilp_pkg::CH_A_UP:cilp_pkg::CH_F_UP]}) begin
      dval = 5'(a_ch_q - cilp_pkg::CH_A_UP + 8'd10);
    end else begin
      dval = 5'd16;
    end
    is_quote = a_ch_q == cilp_pkg::CH_QUOTE;
    is_x     = a_ch_q == cilp_pkg::CH_X_LO || a_ch_q == cilp_pkg::CH_X_UP;
    is_b     = a_ch_q == cilp_pkg::CH_B_LO || a_ch_q == cilp_pkg::CH_B_UP;
    is_sfx   = a_ch_q == cilp_pkg::CH_U_LO || a_ch_q == cilp_pkg::CH_U_UP ||
               a_ch_q == cilp_pkg::CH_L_LO || a_ch_q == cilp_pkg::CH_L_UP;
    sfx      = sfx_take(a_ch_q, su_q, lc_q, uf_q);
  end

  // Digit check and constant-radix multiply
  always_comb begin
    case (base_q)
      cilp_pkg::BASE_DEC: begin
        d_ok = dval < 5'd10;
        mac  = (accum_q << 3) + (accum_q << 1);
      end
      cilp_pkg::BASE_OCT: begin
        d_ok = dval < 5'd8;
        mac  = accum_q << 3;
      end
      cilp_pkg::BASE_HEX: begin
        d_ok = dval < 5'd16;
        mac  = accum_q << 4;
      end
      cilp_pkg::BASE_BIN: begin
        d_ok = dval < 5'd2;
        mac  = accum_q << 1;
      end
      default: begin
        d_ok = 1'b0;
        mac  = accum_q;
      end
    endcase
  end

  // Next phase and failure
  always_comb begin
    phase_t = phase_q;
    fail_t  = fail_q;
    if (!fail_q) begin
      case (phase_q)
        cilp_pkg::PH_START: begin
          if (a_ch_q == cilp_pkg::CH_0) begin
            phase_t = cilp_pkg::PH_ZERO;
          end else if (a_ch_q inside {[cilp_pkg::CH_1:cilp_pkg::CH_9]}) begin
            phase_t = cilp_pkg::PH_DIGITS;
          end else begin
            fail_t = 1'b1;
          end
        end
        cilp_pkg::PH_ZERO: begin
          if (is_x || is_b || dval < 5'd8 || is_quote) begin
            phase_t = cilp_pkg::PH_DIGITS;
          end else if (is_sfx) begin
            phase_t = cilp_pkg::PH_SUFFIX;
            fail_t  = sfx.bad;
          end else begin
            fail_t = 1'b1;
          end
        end
        cilp_pkg::PH_DIGITS: begin
          if (d_ok) begin
            phase_t = cilp_pkg::PH_DIGITS;
          end else if (is_quote) begin
            fail_t = !ds_q || pq_q;
          end else if (is_sfx) begin
            if (!ds_q || pq_q) begin
              fail_t = 1'b1;
            end else begin
              phase_t = cilp_pkg::PH_SUFFIX;
              fail_t  = sfx.bad;
            end
          end else begin
            fail_t = 1'b1;
          end
        end
        cilp_pkg::PH_SUFFIX: begin
          fail_t = sfx.bad;
        end
        default: begin
          fail_t = 1'b1;
        end
      endcase
    end
  end

  // Next datapath state
  always_comb begin
    accum_t = accum_q;
    base_t  = base_q;
    ds_t    = ds_q;
    pq_t    = pq_q;
    su_t    = su_q;
    lc_t    = lc_q;
    uf_t    = uf_q;
    if (!fail_q) begin
      case (phase_q)
        cilp_pkg::PH_START: begin
          if (a_ch_q == cilp_pkg::CH_0) begin
            base_t = cilp_pkg::BASE_OCT;
            ds_t   = 1'b1;
          end else if (a_ch_q inside {[cilp_pkg::CH_1:cilp_pkg::CH_9]}) begin
            base_t  = cilp_pkg::BASE_DEC;
            accum_t = cilp_pkg::ValueW'(dval);
            ds_t    = 1'b1;
          end
        end
        cilp_pkg::PH_ZERO: begin
          if (is_x) begin
            base_t = cilp_pkg::BASE_HEX;
            ds_t   = 1'b0;
          end else if (is_b) begin
            base_t = cilp_pkg::BASE_BIN;
            ds_t   = 1'b0;
          end else if (dval < 5'd8) begin
            accum_t = cilp_pkg::ValueW'(dval);
          end else if (is_quote) begin
            pq_t = 1'b1;
          end else if (is_sfx && !sfx.bad) begin
            su_t = sfx.u;
            lc_t = sfx.lc;
            uf_t = sfx.uf;
          end
        end
        cilp_pkg::PH_DIGITS: begin
          if (d_ok) begin
            accum_t = mac + cilp_pkg::ValueW'(dval);
            ds_t    = 1'b1;
            pq_t    = 1'b0;
          end else if (is_quote) begin
            if (ds_q && !pq_q) pq_t = 1'b1;
          end else if (is_sfx && ds_q && !pq_q && !sfx.bad) begin
            su_t = sfx.u;
            lc_t = sfx.lc;
            uf_t = sfx.uf;
          end
        end
        cilp_pkg::PH_SUFFIX: begin
          if (!sfx.bad) begin
            su_t = sfx.u;
            lc_t = sfx.lc;
            uf_t = sfx.uf;
          end
        end
        default: begin
          accum_t = accum_q;
        end
      endcase
    end
  end

  // Token verdict from the updated state
  assign tok_ok = !fail_t && (phase_t == cilp_pkg::PH_ZERO ||
                              phase_t == cilp_pkg::PH_SUFFIX ||
                              (phase_t == cilp_pkg::PH_DIGITS && ds_t && !pq_t));

  // Advance the token state; clear it after the last beat
  always_comb begin
    phase_d = phase_q;
    base_d  = base_q;
    accum_d = accum_q;
    ds_d    = ds_q;
    pq_d    = pq_q;
    su_d    = su_q;
    lc_d    = lc_q;
    uf_d    = uf_q;
    fail_d  = fail_q;
    if (consume) begin
      if (a_last_q) begin
        phase_d = cilp_pkg::PH_START;
        base_d  = cilp_pkg::BASE_DEC;
        accum_d = '0;
        ds_d    = 1'b0;
        pq_d    = 1'b0;
        su_d    = 1'b0;
        lc_d    = 2'd0;
        uf_d    = 1'b0;
        fail_d  = 1'b0;
      end else begin
        phase_d = phase_t;
        base_d  = base_t;
        accum_d = accum_t;
        ds_d    = ds_t;
        pq_d    = pq_t;
        su_d    = su_t;
        lc_d    = lc_t;
        uf_d    = uf_t;
        fail_d  = fail_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cilp_pkg::PH_START;
      base_q  <= cilp_pkg::BASE_DEC;
      accum_q <= '0;
      ds_q    <= 1'b0;
      pq_q    <= 1'b0;
      su_q    <= 1'b0;
      lc_q    <= 2'd0;
      uf_q    <= 1'b0;
      fail_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      base_q  <= base_d;
      accum_q <= accum_d;
      ds_q    <= ds_d;
      pq_q    <= pq_d;
      su_q    <= su_d;
      lc_q    <= lc_d;
      uf_q    <= uf_d;
      fail_q  <= fail_d;
    end
  end

  // Finished-token register
  always_comb begin
    done_valid_d = done_valid_q;
    if (done_ready_i) done_valid_d = 1'b0;
    if (consume && a_last_q) done_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_valid_q <= 1'b0;
    end else begin
      done_valid_q <= done_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && a_last_q) begin
      done_q.ok    <= tok_ok;
      done_q.value <= accum_t;
      done_q.dec   <= base_t == cilp_pkg::BASE_DEC;
      done_q.u     <= su_t;
      done_q.lc    <= lc_t;
    end
  end

  assign done_valid_o = done_valid_q;
  assign done_o       = done_q;

endmodule

FILE: rtl/core/cilp_type.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_type
// Picks the C type of a finished token from its value, base and suffix, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module cilp_type (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        long_is_wide_i,
  input  logic                        done_valid_i,
  output logic                        done_ready_o,
  input  cilp_pkg::done_t             done_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_accepted_o,
  output logic [cilp_pkg::ValueW-1:0] out_value_o,
  output logic [2:0]                  out_type_o
);

  logic                          out_valid_q, out_valid_d;
  logic                          acc_q;
  logic [cilp_pkg::ValueW-1:0]   value_q;
  cilp_pkg::type_code_e          type_q, pick;
  logic [cilp_pkg::NumTypes-1:0] fits, allowed;
  logic                          le_int, le_uint, le_ll, uns_ok;
  logic [2:0]                    start;
  logic                          take;

  assign done_ready_o = !out_valid_q || out_ready_i;
  assign take         = done_valid_i && done_ready_o;

  // Range checks against each candidate's maximum
  always_comb begin
    le_int  = done_i.value[63:31] == '0;
    le_uint = done_i.value[63:32] == '0;
    le_ll   = !done_i.value[63];
    fits[0] = le_int;
    fits[1] = le_uint;
    fits[2] = long_is_wide_i ? le_ll : le_int;
    fits[3] = long_is_wide_i ? 1'b1 : le_uint;
    fits[4] = le_ll;
    fits[5] = 1'b1;
  end

  // First allowed candidate that holds the value
  always_comb begin
    start  = {done_i.lc, 1'b0};
    uns_ok = done_i.u || !done_i.dec;
    for (int i = 0; i < cilp_pkg::NumTypes; i++) begin
      allowed[i] = (3'(i) >= start) && ((i % 2 == 1) ? uns_ok : !done_i.u);
    end
    pick = cilp_pkg::type_code_e'({done_i.lc, done_i.u});
    for (int i = cilp_pkg::NumTypes - 1; i >= 0; i--) begin
      if (allowed[i] && fits[i]) pick = cilp_pkg::type_code_e'(3'(i));
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (take) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q   <= done_i.ok;
      value_q <= done_i.ok ? done_i.value : '0;
      type_q  <= done_i.ok ? pick : cilp_pkg::TYPE_INT;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_accepted_o = acc_q;
  assign out_value_o    = value_q;
  assign out_type_o     = 3'(type_q);

`ifndef SYNTHESIS
  // A rejected token carries zero value and type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !acc_q |-> value_q == '0 && type_q == cilp_pkg::TYPE_INT)
    else $error("rejected token with nonzero payload");

  // Type code stays within the six C types
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> 3'(type_q) <= 3'(cilp_pkg::TYPE_ULLONG))
    else $error("type code out of range");

  // A decimal without u never gets an unsigned type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && done_i.ok && done_i.dec && !done_i.u |=> !type_q[0])
    else $error("unsigned type for unsuffixed decimal");

  // Long suffix never yields int or uint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && done_i.ok && done_i.lc != 2'd0 |=> 3'(type_q) >= 3'(cilp_pkg::TYPE_LONG))
    else $error("long suffix picked a narrower type");
`endif

endmodule

FILE: rtl/core/c_integer_literal_parser.sv
`timescale 1ns / 1ps
// Path: the last character of a token passes the input register, the scanner's
//   finished-token register and the type stage's output register to m_axis.
// Throughput: one character per cycle, except that a last character stalls while
//   the done register is full and not taken; the radix multiply-add sets this figure.
// Reset: rst_ni clears all valids, the token state, and sets long_is_wide to 1.
// ----------------------------------------------------------------------------
// c_integer_literal_parser
// Recognizes a C integer constant, one character per beat, and reports
// acceptance, value modulo 2^64 and the C type on the last beat.
// ----------------------------------------------------------------------------
module c_integer_literal_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,       // long_is_wide
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,      // [7:0] ch
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata       // [0] accepted, [64:1] value, [67:65] type_code
);

  logic                        long_is_wide_q;
  logic                        done_valid, done_ready;
  cilp_pkg::done_t             done;
  logic                        out_acc;
  logic [cilp_pkg::ValueW-1:0] out_value;
  logic [2:0]                  out_type;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_is_wide_q <= 1'b1;
    end else if (cfg_we_i) begin
      long_is_wide_q <= cfg_wdata_i;
    end
  end

  cilp_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_ch_i      (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .done_valid_o (done_valid),
    .done_ready_i (done_ready),
    .done_o       (done)
  );

  cilp_type u_type (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .long_is_wide_i (long_is_wide_q),
    .done_valid_i   (done_valid),
    .done_ready_o   (done_ready),
    .done_i         (done),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_accepted_o (out_acc),
    .out_value_o    (out_value),
    .out_type_o     (out_type)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'b0000, out_type, out_value, out_acc};

endmodule
